/* hw/rtl/lsm_pkg.sv */
// lsm_pkg: shared widths, codes and command/status types of the MAC table.
// No dependencies; every other file of the block imports it.
package lsm_pkg;

  localparam int PORT_W    = 5;
  localparam int TYPE_W    = 16;
  localparam int MAC_W     = 48;
  localparam int LIFE_W    = 4;
  localparam int ACT_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int PORT_COUNT        = 16;

  localparam logic [PORT_W-1:0] CONTROL_PORT = PORT_W'(1);
  localparam logic [PORT_W-1:0] NO_PORT      = '0;
  localparam logic [LIFE_W-1:0] LIFE_RST     = LIFE_W'(10);
  localparam logic [LIFE_W-1:0] LIFE_ONE     = LIFE_W'(1);

  // result actions
  localparam logic [ACT_W-1:0] ACT_FORWARD   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FLOOD     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DROP_SAME = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DROP_TYPE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_AGED      = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CTL_TYPE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_TYPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME  = 2'd2;

  typedef struct packed {
    logic load_in;   // capture the request header
    logic exec;      // classify, age or learn
    logic load_out;  // move the result into the output register
  } lsm_cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } lsm_stat_t;

endpackage

/* hw/rtl/lsm_ifs.sv */
// lsm_ifs: valid/ready channel interfaces of the MAC table (request, result, config).
// Depends on lsm_pkg.
interface lsm_in_if import lsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PORT_W-1:0] in_port;
  logic [TYPE_W-1:0] frame_type;
  logic [MAC_W-1:0]  src_mac;
  logic [MAC_W-1:0]  dst_mac;

  modport source (output valid, in_port, frame_type, src_mac, dst_mac, input ready);
  modport sink   (input valid, in_port, frame_type, src_mac, dst_mac, output ready);
endinterface

interface lsm_out_if import lsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [PORT_W-1:0] out_port;

  modport source (output valid, action, out_port, input ready);
  modport sink   (input valid, action, out_port, output ready);
endinterface

interface lsm_cfg_if import lsm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/lsm_ctrl.sv */
// lsm_ctrl: sequencing state machine of the MAC table (idle, execute, finish).
// Depends on lsm_pkg; drives the datapath through lsm_cmd_t.
module lsm_ctrl import lsm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lsm_stat_t stat,
  output lsm_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    in_ready     = (state_r == S_IDLE) || ((state_r == S_FIN) && stat.out_free);
    cmd.load_in  = in_valid && in_ready;
    cmd.exec     = (state_r == S_EXEC);
    cmd.load_out = (state_r == S_FIN) && stat.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load_in) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) state_nxt = cmd.load_in ? S_EXEC : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

/* hw/rtl/lsm_dp.sv */
// lsm_dp: MAC table datapath - config registers, match cells, aging, learning,
// lookup and the output register. Depends on lsm_pkg; commanded by lsm_ctrl.
module lsm_dp import lsm_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lsm_cmd_t             cmd,
  output lsm_stat_t            stat,
  input  logic [PORT_W-1:0]    in_port,
  input  logic [TYPE_W-1:0]    frame_type,
  input  logic [MAC_W-1:0]     src_mac,
  input  logic [MAC_W-1:0]     dst_mac,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ACT_W-1:0]     out_action,
  output logic [PORT_W-1:0]    out_port
);

  localparam int N = TABLE_ENTRIES;
  localparam logic [N-1:0] ONE_N = N'(1);

  // captured request
  logic [PORT_W-1:0] port_r;
  logic [TYPE_W-1:0] type_r;
  logic [MAC_W-1:0]  src_r, dst_r;

  // config
  logic [TYPE_W-1:0] ctl_type_r, data_type_r;
  logic [LIFE_W-1:0] life_cfg_r;

  // table cells
  logic [N-1:0]      valid_r, valid_nxt;
  logic [MAC_W-1:0]  mac_r   [N];
  logic [MAC_W-1:0]  mac_nxt [N];
  logic [PORT_W-1:0] eport_r   [N];
  logic [PORT_W-1:0] eport_nxt [N];
  logic [LIFE_W-1:0] life_r   [N];
  logic [LIFE_W-1:0] life_nxt [N];

  // per-item result held between execute and finish
  logic             data_r;
  logic [ACT_W-1:0] act_r;

  logic              out_valid_r, out_valid_nxt;
  logic [ACT_W-1:0]  out_action_r;
  logic [PORT_W-1:0] out_port_r;

  logic             is_ctl, ctl_ok, port_ok, data_ok, do_age, do_learn;
  logic [N-1:0]     hit_vec, free_vec, new_vec, dm_vec, dsel_vec;
  logic             any_hit, dst_hit;
  logic [PORT_W-1:0] found;
  logic [ACT_W-1:0] res_action;
  logic [PORT_W-1:0] res_port;

  // classification of the captured header
  always_comb begin
    is_ctl   = (port_r == CONTROL_PORT);
    ctl_ok   = (type_r == ctl_type_r);
    port_ok  = (port_r != NO_PORT) && (32'(port_r) <= PORT_COUNT);
    data_ok  = !is_ctl && port_ok && (type_r == data_type_r);
    do_age   = cmd.exec && is_ctl && ctl_ok;
    do_learn = cmd.exec && data_ok;
  end

  // source match and lowest free slot
  always_comb begin
    for (int i = 0; i < N; i++) begin
      hit_vec[i] = valid_r[i] && (mac_r[i] == src_r);
    end
    any_hit  = |hit_vec;
    free_vec = ~valid_r;
    new_vec  = free_vec & (valid_r + ONE_N);
  end

  // per-cell next state: aging tick or learn/refresh
  always_comb begin
    for (int i = 0; i < N; i++) begin
      valid_nxt[i] = valid_r[i];
      mac_nxt[i]   = mac_r[i];
      eport_nxt[i] = eport_r[i];
      life_nxt[i]  = life_r[i];
      if (do_age && valid_r[i]) begin
        if (life_r[i] <= LIFE_ONE) begin
          valid_nxt[i] = 1'b0;
          life_nxt[i]  = '0;
        end else begin
          life_nxt[i] = life_r[i] - LIFE_ONE;
        end
      end
      if (do_learn) begin
        if (any_hit) begin
          if (hit_vec[i]) begin
            life_nxt[i]  = life_cfg_r;
            eport_nxt[i] = port_r;
          end
        end else if (new_vec[i]) begin
          valid_nxt[i] = 1'b1;
          life_nxt[i]  = life_cfg_r;
          eport_nxt[i] = port_r;
          mac_nxt[i]   = src_r;
        end
      end
    end
  end

  // destination lookup on the table as left by learning
  always_comb begin
    for (int i = 0; i < N; i++) begin
      dm_vec[i] = valid_r[i] && (mac_r[i] == dst_r);
    end
    dst_hit  = |dm_vec;
    dsel_vec = dm_vec & ((~dm_vec) + ONE_N);
    found    = '0;
    for (int i = 0; i < N; i++) begin
      if (dsel_vec[i]) found = found | eport_r[i];
    end
    res_port = NO_PORT;
    if (!data_r) begin
      res_action = act_r;
    end else if (!dst_hit) begin
      res_action = ACT_FLOOD;
    end else if (found == port_r) begin
      res_action = ACT_DROP_SAME;
    end else begin
      res_action = ACT_FORWARD;
      res_port   = found;
    end
  end

  always_comb begin
    stat.out_free = !out_valid_r || out_ready;
    if (cmd.load_out)  out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else               out_valid_nxt = out_valid_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      ctl_type_r  <= '0;
      data_type_r <= '0;
      life_cfg_r  <= LIFE_RST;
    end else begin
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CTL_TYPE:  ctl_type_r  <= cfg_data;
          CFG_DATA_TYPE: data_type_r <= cfg_data;
          CFG_LIFETIME:  life_cfg_r  <= cfg_data[LIFE_W-1:0];
          default:       ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      mac_r[i]   <= mac_nxt[i];
      eport_r[i] <= eport_nxt[i];
      life_r[i]  <= life_nxt[i];
    end
    if (cmd.load_in) begin
      port_r <= in_port;
      type_r <= frame_type;
      src_r  <= src_mac;
      dst_r  <= dst_mac;
    end
    if (cmd.exec) begin
      data_r <= data_ok;
      act_r  <= (is_ctl && ctl_ok) ? ACT_AGED : ACT_DROP_TYPE;
    end
    if (cmd.load_out) begin
      out_action_r <= res_action;
      out_port_r   <= res_port;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_action = out_action_r;
  assign out_port   = out_port_r;

endmodule

/* hw/rtl/learning_switch_mac_table.sv */
// learning_switch_mac_table: top level of the learning switch MAC table.
// Depends on lsm_pkg, lsm_ifs, lsm_ctrl and lsm_dp.
//
// Usage:
//  - in_req carries one frame header per request (ingress port, ether type,
//    source MAC, destination MAC). out_res returns exactly one result per
//    request: action and egress port (egress is 0 unless forwarding).
//  - cfg_wr writes the control ether type, data ether type and entry lifetime
//    by register index; it is always ready. Write only while no request is
//    in flight.
//  - A header on the control port with the control type ages every entry; a
//    header on a data port with the data type learns or refreshes its source,
//    then looks up the destination to forward, flood or drop.
//  - A request accepted from in_req is captured, then executed by the
//    controller's execute step (classify/age/learn) and then its finish step
//    (lookup into the output register). A new request is accepted only while
//    idle or in the finish step when the output register is free.
//  - The whole table is a row of match cells compared in parallel, so neither
//    learning nor lookup depends on table occupancy.
//  - Reset (rst_n low, synchronous) clears all entry valid bits at once and
//    restores register defaults; no clearing pass is needed.
//  - If out_res stalls, the result waits in the output register; the next
//    request is still executed and waits in the finish step until the output
//    register frees.
module learning_switch_mac_table import lsm_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  lsm_in_if.sink    in_req,
  lsm_out_if.source out_res,
  lsm_cfg_if.sink   cfg_wr
);

  lsm_cmd_t  cmd;
  lsm_stat_t stat;

  // config port never back-pressures
  assign cfg_wr.ready = 1'b1;

  lsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lsm_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_port    (in_req.in_port),
    .frame_type (in_req.frame_type),
    .src_mac    (in_req.src_mac),
    .dst_mac    (in_req.dst_mac),
    .cfg_we     (cfg_wr.valid),
    .cfg_index  (cfg_wr.index),
    .cfg_data   (cfg_wr.data),
    .out_valid  (out_res.valid),
    .out_ready  (out_res.ready),
    .out_action (out_res.action),
    .out_port   (out_res.out_port)
  );

  // an accepted request always passes through execute before the next one is accepted
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("request accepted while previous one not executed");

  // a result only enters the output register when it is free
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.out_free)
    else $error("result loaded over a pending one");

  // a result appears only after a load by the controller
  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_res.valid) |-> $past(cmd.load_out))
    else $error("result valid without a load");

  // execute follows acceptance in the next cycle
  a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |=> cmd.exec)
    else $error("accepted request not executed");

endmodule
